// ===== hw/rtl/rmq_pkg.sv =====
`default_nettype none
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    localparam int NUM_W     = DATA_W + 1;
    // radicand is at most one + three full-scale entries
    localparam int RAD_W     = (FRAC_BITS > DATA_W) ? FRAC_BITS + 2 : DATA_W + 2;
    localparam int SQ_STAGES = (RAD_W + FRAC_BITS + 3) / 4;
    localparam int ROOT_W    = 2 * SQ_STAGES;
    localparam int SQ_IN_W   = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int QB        = DATA_W - 1;
    localparam int DIV_STEP  = 3;
    localparam int DIV_STAGES = (QB + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_A     = ROOT_W + 1 + QB;
    localparam int DIV_B     = NUM_W + FRAC_BITS + 1;
    localparam int DIV_W     = (DIV_A > DIV_B) ? DIV_A : DIV_B;
    localparam int BIG_W     = (ROOT_W > DATA_W) ? ROOT_W : DATA_W;

    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } t_sel;

    typedef logic [8:0][DATA_W-1:0] t_mat;
    typedef logic signed [NUM_W-1:0] t_num;

    typedef struct packed {
        t_sel            sel;
        t_num [2:0]      num;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        t_side            side;
    } t_front;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        t_side             side;
    } t_root;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [SQ_IN_W-1:0] val;
    } t_sq;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QB-1:0]    q;
    } t_dl;

    typedef struct packed {
        t_sel              sel;
        logic [ROOT_W-1:0] big;
        logic              bad;
    } t_dside;

    typedef struct packed {
        t_dl [2:0]       ln;
        logic [2:0]      ovf;
        logic [2:0]      neg;
        logic [ROOT_W:0] s;
        t_dside          ds;
    } t_dstage;

    // two digits of the integer square root
    function automatic t_sq sq_stage(t_sq a);
        t_sq              r;
        logic [REM_W-1:0] trial;
        r = a;
        for (int i = 0; i < 2; i++) begin
            r.rem = {r.rem[REM_W-3:0], r.val[SQ_IN_W-1 -: 2]};
            r.val = r.val << 2;
            trial = {r.root, 2'b01};
            if (r.rem >= trial) begin
                r.rem  = r.rem - trial;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end else begin
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // restoring division steps for quotient bits base down to base-DIV_STEP+1
    function automatic t_dl div_steps(t_dl a, logic [ROOT_W:0] s, int base);
        t_dl              r;
        logic [DIV_W-1:0] dv;
        r = a;
        for (int j = 0; j < DIV_STEP; j++) begin
            if (base - j >= 0) begin
                dv = DIV_W'(s) << (base - j);
                if (r.rem >= dv) begin
                    r.rem = r.rem - dv;
                    r.q   = {r.q[QB-2:0], 1'b1};
                end else begin
                    r.q   = {r.q[QB-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
`default_nettype none
module rmq_front import rmq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_mat   i_mat,
    output logic   o_valid,
    input  logic   i_ready,
    output t_front o_data
);

    localparam int SW = RAD_W + 2;

    logic signed [SW-1:0]     a [9];
    logic signed [DATA_W-1:0] e [9];
    logic signed [SW-1:0]     w_one;
    logic signed [SW-1:0]     w_tr;
    logic signed [SW-1:0]     w_rad;
    t_front                   n_data;
    t_front                   r_data;
    logic                     r_vld;
    logic                     w_en;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            e[k] = $signed(i_mat[k]);
            a[k] = SW'(e[k]);
        end
        w_one = SW'(1) << FRAC_BITS;
        w_tr  = a[0] + a[4] + a[8];
        // strict compares: ties fall to the later branch
        if (w_tr > 0) begin
            n_data.side.sel = SEL_W;
            w_rad = w_tr + w_one;
            n_data.side.num[0] = NUM_W'(e[7]) - NUM_W'(e[5]);
            n_data.side.num[1] = NUM_W'(e[2]) - NUM_W'(e[6]);
            n_data.side.num[2] = NUM_W'(e[3]) - NUM_W'(e[1]);
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            n_data.side.sel = SEL_X;
            w_rad = w_one + a[0] - a[4] - a[8];
            n_data.side.num[0] = NUM_W'(e[7]) - NUM_W'(e[5]);
            n_data.side.num[1] = NUM_W'(e[1]) + NUM_W'(e[3]);
            n_data.side.num[2] = NUM_W'(e[2]) + NUM_W'(e[6]);
        end else if (a[4] > a[8]) begin
            n_data.side.sel = SEL_Y;
            w_rad = w_one + a[4] - a[0] - a[8];
            n_data.side.num[0] = NUM_W'(e[2]) - NUM_W'(e[6]);
            n_data.side.num[1] = NUM_W'(e[1]) + NUM_W'(e[3]);
            n_data.side.num[2] = NUM_W'(e[5]) + NUM_W'(e[7]);
        end else begin
            n_data.side.sel = SEL_Z;
            w_rad = w_one + a[8] - a[0] - a[4];
            n_data.side.num[0] = NUM_W'(e[3]) - NUM_W'(e[1]);
            n_data.side.num[1] = NUM_W'(e[2]) + NUM_W'(e[6]);
            n_data.side.num[2] = NUM_W'(e[5]) + NUM_W'(e[7]);
        end
        n_data.rad = (w_rad < 0) ? '0 : w_rad[RAD_W-1:0];
    end

    assign w_en    = !r_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_sqrt.sv =====
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_root  o_data
);

    logic  r_vld  [SQ_STAGES];
    t_sq   r_sq   [SQ_STAGES];
    t_side r_side [SQ_STAGES];
    logic  w_en   [SQ_STAGES];
    logic  w_sv   [SQ_STAGES];
    t_sq   w_sin  [SQ_STAGES];
    t_side w_side [SQ_STAGES];

    genvar k;
    for (k = 0; k < SQ_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_sv[k]       = i_valid;
            assign w_sin[k].rem  = '0;
            assign w_sin[k].root = '0;
            assign w_sin[k].val  = SQ_IN_W'(i_data.rad) << FRAC_BITS;
            assign w_side[k]     = i_data.side;
        end else begin : g_next
            assign w_sv[k]   = r_vld[k-1];
            assign w_sin[k]  = r_sq[k-1];
            assign w_side[k] = r_side[k-1];
        end

        if (k == SQ_STAGES - 1) begin : g_last
            assign w_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_sv[k]) begin
                r_sq[k]   <= sq_stage(w_sin[k]);
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_ready     = w_en[0];
    assign o_valid     = r_vld[SQ_STAGES-1];
    assign o_data.root = r_sq[SQ_STAGES-1].root;
    assign o_data.side = r_side[SQ_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div.sv =====
`default_nettype none
module rmq_div import rmq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_root   i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dstage o_data
);

    t_dstage          n_pre;
    t_dstage          r_pre;
    logic             r_pvld;
    logic             w_pen;
    logic [ROOT_W:0]  w_rp1;
    logic [DIV_W-1:0] w_lim;
    logic [NUM_W-1:0] w_mag [3];

    logic    r_vld [DIV_STAGES];
    t_dstage r_st  [DIV_STAGES];
    logic    w_en  [DIV_STAGES];
    logic    w_sv  [DIV_STAGES];
    t_dstage w_sin [DIV_STAGES];
    t_dstage w_nx  [DIV_STAGES];

    // set up divisor, rounded dividends and the saturation test
    always_comb begin
        n_pre.s      = {i_data.root, 1'b0};
        w_rp1        = {1'b0, i_data.root} + 1'b1;
        n_pre.ds.big = w_rp1[ROOT_W:1];
        n_pre.ds.bad = (i_data.root == '0);
        n_pre.ds.sel = i_data.side.sel;
        w_lim        = DIV_W'(n_pre.s) << QB;
        for (int j = 0; j < 3; j++) begin
            n_pre.neg[j]   = i_data.side.num[j][NUM_W-1];
            w_mag[j]       = n_pre.neg[j] ? NUM_W'(-i_data.side.num[j])
                                          : NUM_W'(i_data.side.num[j]);
            n_pre.ln[j].rem = DIV_W'({w_mag[j], {FRAC_BITS{1'b0}}})
                            + DIV_W'(i_data.root);
            n_pre.ln[j].q   = '0;
            n_pre.ovf[j]    = (n_pre.ln[j].rem >= w_lim);
        end
    end

    assign w_pen   = !r_pvld || w_en[0];
    assign o_ready = w_pen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (w_pen) begin
            r_pvld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pen && i_valid) begin
            r_pre <= n_pre;
        end
    end

    genvar k;
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_sv[k]  = r_pvld;
            assign w_sin[k] = r_pre;
        end else begin : g_next
            assign w_sv[k]  = r_vld[k-1];
            assign w_sin[k] = r_st[k-1];
        end

        if (k == DIV_STAGES - 1) begin : g_last
            assign w_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end

        always_comb begin
            w_nx[k] = w_sin[k];
            for (int j = 0; j < 3; j++) begin
                w_nx[k].ln[j] = div_steps(w_sin[k].ln[j], w_sin[k].s,
                                          QB - 1 - DIV_STEP * k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_sv[k]) begin
                r_st[k] <= w_nx[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_data  = r_st[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
`default_nettype none
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: nine matrix entries
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: x, y, z, w; tuser: bad_input
//
// one matrix per cycle unless m_axis_tready stalls the pipe; stages: front end 1, square root 8
// (two root digits per stage), divider set-up 1, division 5 (three quotient
// bits per stage in each of three lanes), output register 1
// synchronous active-low reset empties every stage; data registers keep content
// each stage moves on when it is empty or the one after it moves, so bubbles
// close up under a stall and no transaction is dropped or repeated
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2
    input  logic [143:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [63:0]    m_axis_tdata,
    // bad_input
    output logic           m_axis_tuser
);

    localparam logic signed [DATA_W-1:0] QMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] QMIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic    w_fv, w_fr;
    t_front  w_fd;
    logic    w_sv, w_sr;
    t_root   w_sd;
    logic    w_dv, w_dr;
    t_dstage w_dd;

    logic                     r_vld;
    logic [3:0][DATA_W-1:0]   r_quat;
    logic                     r_bad;
    logic [3:0][DATA_W-1:0]   n_quat;
    logic signed [DATA_W-1:0] w_res [3];
    logic [BIG_W-1:0]         w_bigx;
    logic signed [DATA_W-1:0] w_big;
    logic                     w_en;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mat   (s_axis_tdata),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_data  (w_fd)
    );

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_data  (w_fd),
        .o_valid (w_sv),
        .i_ready (w_sr),
        .o_data  (w_sd)
    );

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sv),
        .o_ready (w_sr),
        .i_data  (w_sd),
        .o_valid (w_dv),
        .i_ready (w_dr),
        .o_data  (w_dd)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (w_dd.ovf[j]) begin
                w_res[j] = w_dd.neg[j] ? QMIN : QMAX;
            end else if (w_dd.neg[j]) begin
                w_res[j] = -$signed({1'b0, w_dd.ln[j].q});
            end else begin
                w_res[j] = $signed({1'b0, w_dd.ln[j].q});
            end
        end
        w_bigx = BIG_W'(w_dd.ds.big);
        w_big  = (w_bigx > BIG_W'(QMAX)) ? QMAX : w_bigx[DATA_W-1:0];
        case (w_dd.ds.sel)
            SEL_W: begin
                n_quat = {w_big, w_res[2], w_res[1], w_res[0]};
            end
            SEL_X: begin
                n_quat = {w_res[0], w_res[2], w_res[1], w_big};
            end
            SEL_Y: begin
                n_quat = {w_res[0], w_res[2], w_big, w_res[1]};
            end
            SEL_Z: begin
                n_quat = {w_res[0], w_big, w_res[2], w_res[1]};
            end
            default: begin
                n_quat = '0;
            end
        endcase
        // zero divisor forces every component to zero
        if (w_dd.ds.bad) begin
            n_quat = '0;
        end
    end

    assign w_en = !r_vld || m_axis_tready;
    assign w_dr = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_dv) begin
            r_quat <= n_quat;
            r_bad  <= w_dd.ds.bad;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_quat;
    assign m_axis_tuser  = r_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad input result carries non-zero components");

    a_good_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
        else $error("valid quaternion has no non-zero component");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

endmodule
`default_nettype wire
